// ===== src/vialu_pkg.sv =====
`timescale 1ns / 1ps
package vialu_pkg;

  localparam int DATA_W  = 64;
  localparam int MUL_LAT = 4;
  localparam int DIV_LAT = 66;

  localparam logic [5:0] OP_ADD    = 6'd0;
  localparam logic [5:0] OP_SUB    = 6'd1;
  localparam logic [5:0] OP_RSUB   = 6'd2;
  localparam logic [5:0] OP_AND    = 6'd3;
  localparam logic [5:0] OP_OR     = 6'd4;
  localparam logic [5:0] OP_XOR    = 6'd5;
  localparam logic [5:0] OP_MIN    = 6'd6;
  localparam logic [5:0] OP_MAX    = 6'd7;
  localparam logic [5:0] OP_MINU   = 6'd8;
  localparam logic [5:0] OP_MAXU   = 6'd9;
  localparam logic [5:0] OP_MOVE   = 6'd10;
  localparam logic [5:0] OP_ADC    = 6'd11;
  localparam logic [5:0] OP_SBC    = 6'd12;
  localparam logic [5:0] OP_MADC   = 6'd13;
  localparam logic [5:0] OP_MSBC   = 6'd14;
  localparam logic [5:0] OP_SLL    = 6'd15;
  localparam logic [5:0] OP_SRL    = 6'd16;
  localparam logic [5:0] OP_SRA    = 6'd17;
  localparam logic [5:0] OP_MULHU  = 6'd18;
  localparam logic [5:0] OP_MUL    = 6'd19;
  localparam logic [5:0] OP_MULSU  = 6'd20;
  localparam logic [5:0] OP_MULHSU = 6'd21;
  localparam logic [5:0] OP_MULH   = 6'd22;
  localparam logic [5:0] OP_MACC   = 6'd23;
  localparam logic [5:0] OP_MACCSU = 6'd24;
  localparam logic [5:0] OP_MACCUS = 6'd25;
  localparam logic [5:0] OP_NMSAC  = 6'd26;
  localparam logic [5:0] OP_MADD   = 6'd27;
  localparam logic [5:0] OP_NMSUB  = 6'd28;
  localparam logic [5:0] OP_DIVU   = 6'd29;
  localparam logic [5:0] OP_DIV    = 6'd30;
  localparam logic [5:0] OP_REMU   = 6'd31;
  localparam logic [5:0] OP_REM    = 6'd32;
  localparam logic [5:0] OP_MERGE  = 6'd33;
  localparam logic [5:0] OP_MSEQ   = 6'd34;
  localparam logic [5:0] OP_MSNE   = 6'd35;
  localparam logic [5:0] OP_MSLTU  = 6'd36;
  localparam logic [5:0] OP_MSLT   = 6'd37;
  localparam logic [5:0] OP_MSLEU  = 6'd38;
  localparam logic [5:0] OP_MSLE   = 6'd39;
  localparam logic [5:0] OP_MSGTU  = 6'd40;
  localparam logic [5:0] OP_MSGT   = 6'd41;

  localparam logic [1:0] CLS_SIMPLE = 2'd0;
  localparam logic [1:0] CLS_MUL    = 2'd1;
  localparam logic [1:0] CLS_DIV    = 2'd2;

  localparam logic [1:0] MODE_PLUS  = 2'd0;
  localparam logic [1:0] MODE_MINUS = 2'd1;
  localparam logic [1:0] MODE_SHR   = 2'd2;

  typedef struct packed {
    logic [63:0] ll;
    logic [63:0] lh;
    logic [63:0] hl;
    logic [63:0] hh;
    logic [63:0] corr;
    logic [63:0] addend;
    logic [1:0]  mode;
    logic [6:0]  sw;
  } mul_in_t;

  typedef struct packed {
    logic [63:0] num;
    logic [63:0] den;
    logic        is_rem;
    logic        negq;
    logic        negr;
  } div_in_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] nq;
    logic [63:0] den;
    logic        is_rem;
    logic        negq;
    logic        negr;
  } div_stage_t;

  typedef struct packed {
    logic [1:0]  cls;
    logic [63:0] simple;
    logic        md;
    logic [6:0]  dw;
    logic        off;
  } ctrl_t;

  function automatic logic [63:0] lowmask(input logic [6:0] w);
    return (w >= 7'd64) ? '1 : ((64'd1 << w) - 64'd1);
  endfunction

  function automatic logic [63:0] sext(input logic [63:0] x, input logic [6:0] w);
    logic [63:0] m;
    logic        s;
    m = lowmask(w);
    s = x[6'(w - 7'd1)];
    return (x & m) | ({64{s}} & ~m);
  endfunction

endpackage

// ===== src/vector_integer_element_alu_top.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Width  Contents
// in_      in   208    op, sew, widen, narrow, signed_ops, operand_a, operand_b,
//                      old_dest, mask_bit, masked, mask_dest
// out_     out  72     result, write_enable
// The pipeline takes one element per cycle while it is not stalled by the output.
// The 64-stage restoring divider, one quotient bit per stage, sets the depth.
// Every stage advances together when the output register is empty or being taken.
// rst_n clears only the valid bits; the pipeline holds in place while out_tvalid is high and out_tready is low.
module vector_integer_element_alu_top #(
  parameter int MAX_ELEM_BITS = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // op[5:0] sew[7:6] widen[8] narrow[9] signed_ops[10] operand_a[74:11]
  // operand_b[138:75] old_dest[202:139] mask_bit[203] masked[204] mask_dest[205]
  input  logic [207:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // result[63:0] write_enable[64]
  output logic [71:0]  out_tdata
);

  localparam int CTRL_DEPTH = vialu_pkg::DIV_LAT;
  localparam int MUL_DEPTH  = vialu_pkg::DIV_LAT - vialu_pkg::MUL_LAT;

  logic               en;
  logic               s1_valid;
  vialu_pkg::ctrl_t   s1_ctrl;
  vialu_pkg::mul_in_t s1_mul;
  vialu_pkg::div_in_t s1_div;
  logic [63:0]        mul_res, div_res;

  logic             vdl_r    [0:CTRL_DEPTH-1];
  vialu_pkg::ctrl_t ctrl_dl_r [0:CTRL_DEPTH-1];
  logic [63:0]      mul_dl_r  [0:MUL_DEPTH-1];

  logic        out_valid_r;
  logic [71:0] out_data_r;
  logic [63:0] r_sel, res_nxt;
  vialu_pkg::ctrl_t c;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  vialu_front #(.MAX_ELEM_BITS(MAX_ELEM_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_tvalid),
    .op         (in_tdata[5:0]),
    .sew        (in_tdata[7:6]),
    .widen      (in_tdata[8]),
    .narrow     (in_tdata[9]),
    .signed_ops (in_tdata[10]),
    .operand_a  (in_tdata[74:11]),
    .operand_b  (in_tdata[138:75]),
    .old_dest   (in_tdata[202:139]),
    .mask_bit   (in_tdata[203]),
    .masked     (in_tdata[204]),
    .mask_dest  (in_tdata[205]),
    .valid_o    (s1_valid),
    .ctrl_o     (s1_ctrl),
    .mul_o      (s1_mul),
    .div_o      (s1_div)
  );

  vialu_mul u_mul (
    .clk   (clk),
    .en    (en),
    .mul_i (s1_mul),
    .res_o (mul_res)
  );

  vialu_div u_div (
    .clk   (clk),
    .en    (en),
    .div_i (s1_div),
    .res_o (div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CTRL_DEPTH; i++) begin
        vdl_r[i] <= 1'b0;
      end
    end else if (en) begin
      vdl_r[0] <= s1_valid;
      for (int i = 1; i < CTRL_DEPTH; i++) begin
        vdl_r[i] <= vdl_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl_dl_r[0] <= s1_ctrl;
      for (int i = 1; i < CTRL_DEPTH; i++) begin
        ctrl_dl_r[i] <= ctrl_dl_r[i-1];
      end
      mul_dl_r[0] <= mul_res;
      for (int i = 1; i < MUL_DEPTH; i++) begin
        mul_dl_r[i] <= mul_dl_r[i-1];
      end
    end
  end

  always_comb begin
    c = ctrl_dl_r[CTRL_DEPTH-1];
    case (c.cls)
      vialu_pkg::CLS_MUL: r_sel = mul_dl_r[MUL_DEPTH-1];
      vialu_pkg::CLS_DIV: r_sel = div_res;
      default:            r_sel = c.simple;
    endcase
    if (c.off) begin
      res_nxt = '0;
    end else if (c.md) begin
      res_nxt = {63'b0, r_sel[0]};
    end else begin
      res_nxt = r_sel & vialu_pkg::lowmask(c.dw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vdl_r[CTRL_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {7'b0, !c.off, res_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[64] |-> out_tdata[63:0] == 64'd0)
    else $error("masked-off element carries nonzero result");

  a_mask_one_bit: assert property (@(posedge clk) disable iff (!rst_n)
    vdl_r[CTRL_DEPTH-1] && en && ctrl_dl_r[CTRL_DEPTH-1].md
    |=> out_tdata[63:1] == 63'd0)
    else $error("mask destination wider than one bit");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready out of step with output stall");

  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

// ===== src/vialu_front.sv =====
`timescale 1ns / 1ps
module vialu_front #(
  parameter int MAX_ELEM_BITS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [5:0]          op,
  input  logic [1:0]          sew,
  input  logic                widen,
  input  logic                narrow,
  input  logic                signed_ops,
  input  logic [63:0]         operand_a,
  input  logic [63:0]         operand_b,
  input  logic [63:0]         old_dest,
  input  logic                mask_bit,
  input  logic                masked,
  input  logic                mask_dest,
  output logic                valid_o,
  output vialu_pkg::ctrl_t    ctrl_o,
  output vialu_pkg::mul_in_t  mul_o,
  output vialu_pkg::div_in_t  div_o
);

  localparam logic [7:0] MAXW = 8'(MAX_ELEM_BITS);

  function automatic logic [6:0] clampw(input logic [2:0] k);
    logic [7:0] full;
    full = 8'd8 << k;
    return (full > MAXW) ? MAXW[6:0] : full[6:0];
  endfunction

  logic        v0_r, sel0_r, cin0_r, off0_r, md0_r, narrow0_r;
  logic [5:0]  op0_r;
  logic [63:0] a0_r, b0_r, d0_r;
  logic [6:0]  sw0_r, aw0_r, dw0_r;

  logic [6:0]  sw_nxt, aw_nxt, dw_nxt;
  logic [63:0] a_nxt, b_nxt;
  logic        off_nxt;

  always_comb begin
    sw_nxt = clampw({1'b0, sew});
    aw_nxt = clampw(3'(sew) + 3'(narrow));
    dw_nxt = clampw(3'(sew) + 3'(widen));
    a_nxt  = operand_a & vialu_pkg::lowmask(aw_nxt);
    b_nxt  = operand_b & vialu_pkg::lowmask(sw_nxt);
    if (signed_ops) begin
      a_nxt = vialu_pkg::sext(a_nxt, aw_nxt);
      b_nxt = vialu_pkg::sext(b_nxt, sw_nxt);
    end
    off_nxt = masked && !mask_bit && op != vialu_pkg::OP_MERGE &&
              op != vialu_pkg::OP_ADC && op != vialu_pkg::OP_SBC &&
              op != vialu_pkg::OP_MADC && op != vialu_pkg::OP_MSBC;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op0_r     <= op;
      a0_r      <= a_nxt;
      b0_r      <= b_nxt;
      d0_r      <= old_dest;
      sw0_r     <= sw_nxt;
      aw0_r     <= aw_nxt;
      dw0_r     <= dw_nxt;
      narrow0_r <= narrow;
      cin0_r    <= masked & mask_bit;
      sel0_r    <= masked ? mask_bit : 1'b1;
      off0_r    <= off_nxt;
      md0_r     <= mask_dest;
    end
  end

  logic [63:0] m, sa, sb, ma, mb, x, y, n, dv;
  logic [6:0]  wsel;
  logic [5:0]  sh_l, sh_r;
  logic        sgn, dz;
  vialu_pkg::ctrl_t   ctrl_nxt;
  vialu_pkg::mul_in_t mul_nxt;
  vialu_pkg::div_in_t div_nxt;

  always_comb begin
    m    = vialu_pkg::lowmask(sw0_r);
    sa   = vialu_pkg::sext(a0_r, sw0_r);
    sb   = vialu_pkg::sext(b0_r, sw0_r);
    ma   = a0_r & m;
    mb   = b0_r & m;
    wsel = narrow0_r ? aw0_r : sw0_r;
    sh_l = b0_r[5:0] & 6'(sw0_r - 7'd1);
    sh_r = b0_r[5:0] & 6'(wsel - 7'd1);

    ctrl_nxt.cls    = vialu_pkg::CLS_SIMPLE;
    ctrl_nxt.md     = md0_r;
    ctrl_nxt.dw     = dw0_r;
    ctrl_nxt.off    = off0_r;
    ctrl_nxt.simple = b0_r;
    case (op0_r)
      vialu_pkg::OP_ADD:   ctrl_nxt.simple = a0_r + b0_r;
      vialu_pkg::OP_SUB:   ctrl_nxt.simple = a0_r - b0_r;
      vialu_pkg::OP_RSUB:  ctrl_nxt.simple = b0_r - a0_r;
      vialu_pkg::OP_AND:   ctrl_nxt.simple = a0_r & b0_r;
      vialu_pkg::OP_OR:    ctrl_nxt.simple = a0_r | b0_r;
      vialu_pkg::OP_XOR:   ctrl_nxt.simple = a0_r ^ b0_r;
      vialu_pkg::OP_MIN:   ctrl_nxt.simple = ($signed(a0_r) < $signed(b0_r)) ? a0_r : b0_r;
      vialu_pkg::OP_MAX:   ctrl_nxt.simple = ($signed(a0_r) < $signed(b0_r)) ? b0_r : a0_r;
      vialu_pkg::OP_MINU:  ctrl_nxt.simple = (a0_r < b0_r) ? a0_r : b0_r;
      vialu_pkg::OP_MAXU:  ctrl_nxt.simple = (a0_r < b0_r) ? b0_r : a0_r;
      vialu_pkg::OP_MOVE:  ctrl_nxt.simple = a0_r;
      vialu_pkg::OP_ADC:   ctrl_nxt.simple = a0_r + b0_r + 64'(cin0_r);
      vialu_pkg::OP_SBC:   ctrl_nxt.simple = a0_r - b0_r - 64'(cin0_r);
      vialu_pkg::OP_MADC:
        ctrl_nxt.simple = 64'((ma > m - mb) || (cin0_r && (ma + mb == m)));
      vialu_pkg::OP_MSBC:
        ctrl_nxt.simple = (cin0_r && mb == m) ? 64'd1 : 64'(ma < mb + 64'(cin0_r));
      vialu_pkg::OP_SLL:   ctrl_nxt.simple = a0_r << sh_l;
      vialu_pkg::OP_SRL:   ctrl_nxt.simple = a0_r >> sh_r;
      vialu_pkg::OP_SRA:
        ctrl_nxt.simple = $signed(vialu_pkg::sext(a0_r, wsel)) >>> sh_r;
      vialu_pkg::OP_MERGE: ctrl_nxt.simple = sel0_r ? b0_r : a0_r;
      vialu_pkg::OP_MSEQ:  ctrl_nxt.simple = 64'(a0_r == b0_r);
      vialu_pkg::OP_MSNE:  ctrl_nxt.simple = 64'(a0_r != b0_r);
      vialu_pkg::OP_MSLTU: ctrl_nxt.simple = 64'(a0_r < b0_r);
      vialu_pkg::OP_MSLT:  ctrl_nxt.simple = 64'($signed(a0_r) < $signed(b0_r));
      vialu_pkg::OP_MSLEU: ctrl_nxt.simple = 64'(a0_r <= b0_r);
      vialu_pkg::OP_MSLE:  ctrl_nxt.simple = 64'($signed(a0_r) <= $signed(b0_r));
      vialu_pkg::OP_MSGTU: ctrl_nxt.simple = 64'(a0_r > b0_r);
      vialu_pkg::OP_MSGT:  ctrl_nxt.simple = 64'($signed(a0_r) > $signed(b0_r));
      default:             ctrl_nxt.simple = b0_r;
    endcase
    if (op0_r inside {[vialu_pkg::OP_MULHU:vialu_pkg::OP_NMSUB]}) begin
      ctrl_nxt.cls = vialu_pkg::CLS_MUL;
    end else if (op0_r inside {[vialu_pkg::OP_DIVU:vialu_pkg::OP_REM]}) begin
      ctrl_nxt.cls = vialu_pkg::CLS_DIV;
    end

    x = a0_r;
    if (op0_r inside {vialu_pkg::OP_MULSU, vialu_pkg::OP_MULH, vialu_pkg::OP_MACCUS}) begin
      x = sa;
    end else if (op0_r inside {vialu_pkg::OP_MADD, vialu_pkg::OP_NMSUB}) begin
      x = d0_r;
    end
    y = (op0_r inside {vialu_pkg::OP_MULH, vialu_pkg::OP_MACCSU}) ? sb : b0_r;
    mul_nxt.ll   = x[31:0] * y[31:0];
    mul_nxt.lh   = x[31:0] * y[63:32];
    mul_nxt.hl   = x[63:32] * y[31:0];
    mul_nxt.hh   = x[63:32] * y[63:32];
    mul_nxt.sw   = sw0_r;
    mul_nxt.corr = '0;
    if (op0_r == vialu_pkg::OP_MULH) begin
      mul_nxt.corr = (x[63] ? y : 64'd0) + (y[63] ? x : 64'd0);
    end
    mul_nxt.mode   = vialu_pkg::MODE_PLUS;
    mul_nxt.addend = '0;
    case (op0_r)
      vialu_pkg::OP_MULHU, vialu_pkg::OP_MULH: begin
        mul_nxt.mode = vialu_pkg::MODE_SHR;
      end
      vialu_pkg::OP_MULHSU: begin
        mul_nxt.mode   = vialu_pkg::MODE_SHR;
        mul_nxt.addend = sa[63] ? b0_r : 64'd0;
      end
      vialu_pkg::OP_MACC, vialu_pkg::OP_MACCSU, vialu_pkg::OP_MACCUS: begin
        mul_nxt.addend = d0_r;
      end
      vialu_pkg::OP_NMSAC: begin
        mul_nxt.mode   = vialu_pkg::MODE_MINUS;
        mul_nxt.addend = d0_r;
      end
      vialu_pkg::OP_MADD: begin
        mul_nxt.addend = a0_r;
      end
      vialu_pkg::OP_NMSUB: begin
        mul_nxt.mode   = vialu_pkg::MODE_MINUS;
        mul_nxt.addend = a0_r;
      end
      default: begin
        mul_nxt.mode = vialu_pkg::MODE_PLUS;
      end
    endcase

    sgn = (op0_r == vialu_pkg::OP_DIV) || (op0_r == vialu_pkg::OP_REM);
    n   = sgn ? sa : a0_r;
    dv  = sgn ? sb : b0_r;
    dz  = (dv == 64'd0);
    div_nxt.num    = (sgn && n[63]) ? (64'd0 - n) : n;
    div_nxt.den    = (sgn && dv[63]) ? (64'd0 - dv) : dv;
    div_nxt.is_rem = (op0_r == vialu_pkg::OP_REMU) || (op0_r == vialu_pkg::OP_REM);
    div_nxt.negq   = sgn && (n[63] ^ dv[63]) && !dz;
    div_nxt.negr   = sgn && n[63];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl_o <= ctrl_nxt;
      mul_o  <= mul_nxt;
      div_o  <= div_nxt;
    end
  end

endmodule

// ===== src/vialu_mul.sv =====
`timescale 1ns / 1ps
module vialu_mul (
  input  logic               clk,
  input  logic               en,
  input  vialu_pkg::mul_in_t mul_i,
  output logic [63:0]        res_o
);

  logic [33:0] mid;
  logic [63:0] lo2_r, hip2_r, corr2_r, add2_r;
  logic [1:0]  midc2_r, mode2_r;
  logic [6:0]  sw2_r;
  logic [63:0] lo3_r, hi3_r, add3_r;
  logic [1:0]  mode3_r;
  logic [6:0]  sw3_r;
  logic [63:0] lo4_r, shr4_r, add4_r;
  logic [1:0]  mode4_r;
  logic [63:0] shr_nxt, res_nxt;

  assign mid = {2'b0, mul_i.ll[63:32]} + {2'b0, mul_i.lh[31:0]} + {2'b0, mul_i.hl[31:0]};

  always_comb begin
    if (sw3_r >= 7'd64) begin
      shr_nxt = hi3_r;
    end else begin
      shr_nxt = (lo3_r >> sw3_r) | (hi3_r << (7'd64 - sw3_r));
    end
    case (mode4_r)
      vialu_pkg::MODE_PLUS:  res_nxt = lo4_r + add4_r;
      vialu_pkg::MODE_MINUS: res_nxt = add4_r - lo4_r;
      vialu_pkg::MODE_SHR:   res_nxt = shr4_r - add4_r;
      default:               res_nxt = lo4_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo2_r   <= {mid[31:0], mul_i.ll[31:0]};
      hip2_r  <= mul_i.hh + {32'b0, mul_i.lh[63:32]} + {32'b0, mul_i.hl[63:32]};
      midc2_r <= mid[33:32];
      corr2_r <= mul_i.corr;
      add2_r  <= mul_i.addend;
      mode2_r <= mul_i.mode;
      sw2_r   <= mul_i.sw;
      lo3_r   <= lo2_r;
      hi3_r   <= hip2_r + 64'(midc2_r) - corr2_r;
      add3_r  <= add2_r;
      mode3_r <= mode2_r;
      sw3_r   <= sw2_r;
      lo4_r   <= lo3_r;
      shr4_r  <= shr_nxt;
      add4_r  <= add3_r;
      mode4_r <= mode3_r;
      res_o   <= res_nxt;
    end
  end

endmodule

// ===== src/vialu_div.sv =====
`timescale 1ns / 1ps
module vialu_div (
  input  logic               clk,
  input  logic               en,
  input  vialu_pkg::div_in_t div_i,
  output logic [63:0]        res_o
);

  localparam int N = vialu_pkg::DATA_W;

  vialu_pkg::div_stage_t stage_r [0:N];

  always_ff @(posedge clk) begin
    logic [64:0] t, diff;
    if (en) begin
      stage_r[0].rem    <= '0;
      stage_r[0].nq     <= div_i.num;
      stage_r[0].den    <= div_i.den;
      stage_r[0].is_rem <= div_i.is_rem;
      stage_r[0].negq   <= div_i.negq;
      stage_r[0].negr   <= div_i.negr;
      for (int g = 1; g <= N; g++) begin
        t    = {stage_r[g-1].rem, stage_r[g-1].nq[63]};
        diff = t - {1'b0, stage_r[g-1].den};
        stage_r[g].rem    <= diff[64] ? t[63:0] : diff[63:0];
        stage_r[g].nq     <= {stage_r[g-1].nq[62:0], !diff[64]};
        stage_r[g].den    <= stage_r[g-1].den;
        stage_r[g].is_rem <= stage_r[g-1].is_rem;
        stage_r[g].negq   <= stage_r[g-1].negq;
        stage_r[g].negr   <= stage_r[g-1].negr;
      end
      if (stage_r[N].is_rem) begin
        res_o <= stage_r[N].negr ? (64'd0 - stage_r[N].rem) : stage_r[N].rem;
      end else begin
        res_o <= stage_r[N].negq ? (64'd0 - stage_r[N].nq) : stage_r[N].nq;
      end
    end
  end

endmodule
